FILE: hw/rtl/ssq_pkg.sv
// Shared types and constants for the switchable stack/queue block.
// Used by ssq_ram and switchable_stack_queue; depends on nothing.
package ssq_pkg;

  localparam int BYTE_W = 8;
  localparam int FILL_W = 7;

  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_READ  = 2'd1,
    KIND_MODE  = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_REFUSED = 2'd3
  } status_t;

  typedef logic [BYTE_W-1:0] byte_t;

endpackage

FILE: hw/rtl/switchable_stack_queue.sv
// Top level of the switchable stack/queue: ring pointer control and output register.
// Depends on ssq_pkg and ssq_ram.
//
// A byte store of DEPTH entries that behaves as a FIFO queue (mode 0, the
// reset mode) or as a LIFO stack (mode 1). Every request returns exactly one
// result carrying the removed byte (zero unless a read succeeded), a status
// and the fill count after the request. A write to a full store is dropped
// with status 1, a read of an empty store returns status 2, and a mode change
// is taken only while the store is empty and is refused with status 3
// otherwise. Kind three is ignored and returns status 0. The bytes live in a
// ring held in a synchronous memory with registered read data; head and
// count registers locate the oldest and newest entries. After a successful
// read, the next request waits until the memory read data has been placed
// in the output register. The result sits in an output register, so a new
// request is taken while the previous result is still waiting as long as the
// downstream side takes it in the same cycle. The fill count port is seven
// bits wide and wraps if DEPTH exceeds 127. No clearing pass is needed after
// reset, since no read can reach an entry that has not been written.
module switchable_stack_queue
  import ssq_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  // Request channel.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,  // [7:0] write_byte, [8] requested_mode, rest zero
  input  logic [1:0]  s_tuser,  // [1:0] kind
  // Result channel.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,  // [7:0] read_byte, [14:8] fill_count, rest zero
  output logic [1:0]  m_tuser   // [1:0] status
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW:0]   DEPTH_S = (AW + 1)'(DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  // Wrap a ring sum that is known to stay below twice DEPTH.
  function automatic logic [AW-1:0] ring_wrap(input logic [AW:0] s);
    logic [AW:0] r;
    r = (s >= DEPTH_S) ? (s - DEPTH_S) : s;
    return r[AW-1:0];
  endfunction

  // Control state.
  logic          stack_mode;
  logic [CW-1:0] count;
  logic [AW-1:0] head;
  logic          pend;

  // Output register.
  byte_t             rbyte;
  status_t           status;
  logic [FILL_W-1:0] fill;

  // Request fields.
  kind_t kind;
  byte_t wbyte;
  logic  req_mode;

  assign kind     = kind_t'(s_tuser);
  assign wbyte    = s_tdata[BYTE_W-1:0];
  assign req_mode = s_tdata[BYTE_W];

  logic accept;
  assign s_tready = !pend && (!m_tvalid || m_tready);
  assign accept   = s_tvalid && s_tready;

  // Decode of the accepted request.
  logic          full, empty;
  logic          do_write, do_read;
  logic [AW-1:0] tail_pos, top_pos, head_inc, rd_pos;
  logic [CW-1:0] count_next;
  logic [AW-1:0] head_next;
  logic          mode_next;
  status_t       status_next;

  assign full  = (count == DEPTH_C);
  assign empty = (count == '0);

  // Offsets below are only used when they lie under DEPTH, so AW bits suffice.
  assign tail_pos = ring_wrap({1'b0, head} + {1'b0, count[AW-1:0]});
  assign top_pos  = ring_wrap({1'b0, head} + {1'b0, AW'(count - CW'(1))});
  assign head_inc = ring_wrap({1'b0, head} + (AW + 1)'(1));
  assign rd_pos   = stack_mode ? top_pos : head;

  always_comb begin
    do_write    = 1'b0;
    do_read     = 1'b0;
    count_next  = count;
    head_next   = head;
    mode_next   = stack_mode;
    status_next = ST_OK;
    case (kind)
      KIND_WRITE: begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          do_write   = 1'b1;
          count_next = count + CW'(1);
        end
      end
      KIND_READ: begin
        if (empty) begin
          status_next = ST_EMPTY;
        end else begin
          do_read    = 1'b1;
          count_next = count - CW'(1);
          if (!stack_mode) begin
            head_next = head_inc;
          end
        end
      end
      KIND_MODE: begin
        if (empty) begin
          mode_next = req_mode;
        end else begin
          status_next = ST_REFUSED;
        end
      end
      default: begin
      end
    endcase
  end

  byte_t rdata;

  ssq_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (accept && do_write),
    .waddr (tail_pos),
    .wdata (wbyte),
    .re    (accept && do_read),
    .raddr (rd_pos),
    .rdata (rdata)
  );

  // Pointer and mode registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      head       <= '0;
      stack_mode <= 1'b0;
      pend       <= 1'b0;
    end else begin
      pend <= accept && do_read;
      if (accept) begin
        count      <= count_next;
        head       <= head_next;
        stack_mode <= mode_next;
      end
    end
  end

  // Result valid: raised at the accepting edge for most requests; a read waits
  // in the pend state until the memory data has been captured before raising it.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= !do_read;
    end else if (pend) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rbyte  <= '0;
      status <= status_next;
      fill   <= FILL_W'(count_next);
    end else if (pend) begin
      rbyte <= rdata;
    end
  end

  assign m_tdata = {1'b0, fill, rbyte};
  assign m_tuser = status;

endmodule

FILE: hw/rtl/ssq_ram.sv
// Byte storage of the switchable stack/queue: one write port and one read port,
// read data registered. Depends on ssq_pkg.
module ssq_ram
  import ssq_pkg::*;
#(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  byte_t         wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output byte_t         rdata
);

  byte_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
